FILE: hdl/smx_pkg.sv
package smx_pkg;

   localparam int MaxClasses = 16;
   localparam int IdxW = $clog2(MaxClasses);
   localparam int CntW = $clog2(MaxClasses + 1);
   localparam int ExpW = 17;
   localparam int SumW = 21;
   localparam int Log2eQ16 = 94548;

   // 2^(-k/16) in Q16, k = 0..16
   function automatic logic [16:0] pow2_tab(input logic [4:0] k);
      logic [16:0] v;
      case (k)
         5'd0: v = 17'd65536;
         5'd1: v = 17'd62757;
         5'd2: v = 17'd60096;
         5'd3: v = 17'd57549;
         5'd4: v = 17'd55109;
         5'd5: v = 17'd52773;
         5'd6: v = 17'd50535;
         5'd7: v = 17'd48393;
         5'd8: v = 17'd46341;
         5'd9: v = 17'd44376;
         5'd10: v = 17'd42495;
         5'd11: v = 17'd40693;
         5'd12: v = 17'd38968;
         5'd13: v = 17'd37316;
         5'd14: v = 17'd35734;
         5'd15: v = 17'd34219;
         default: v = 17'd32768;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/smx_ram.sv
module smx_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/smx_divider.sv
// Restoring divider: quotient of (num << 16 + den/2) / den, 34 bit dividend,
// one quotient bit per cycle, result saturated to 16 bits.
module smx_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [smx_pkg::ExpW-1:0]  num,
   input  logic [smx_pkg::SumW-1:0]  den,
   output logic                      done,
   output logic [15:0]               quot
);
   import smx_pkg::*;

   localparam int DivW = ExpW + 16 + 1;
   localparam int StepW = $clog2(DivW + 1);

   logic [DivW-1:0]  dvd_ff, dvd_in;
   logic [DivW-1:0]  q_ff, q_in;
   logic [SumW:0]    rem_ff, rem_in;
   logic [SumW-1:0]  den_ff, den_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SumW:0]    trial;

   always_comb begin
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         dvd_in  = DivW'({num, 16'd0}) + DivW'(den >> 1);
         den_in  = den;
         rem_in  = '0;
         q_in    = '0;
         step_in = StepW'(DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         trial   = {rem_ff[SumW-1:0], dvd_ff[DivW-1]};
         dvd_in  = {dvd_ff[DivW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[DivW-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign quot = (|q_ff[DivW-1:16]) ? 16'hFFFF : q_ff[15:0];

endmodule

FILE: hdl/softmax_normalizer.sv
// Fixed-point softmax. Logits (signed Q8.8) stream in on req_, one transfer
// per cycle, req_tlast closing the vector; up to 16 are kept in a logit RAM,
// and later ones are dropped and reported through the truncated flag. On the
// closing transfer the block stops accepting and walks the stored classes:
// an exponential pass per class (RAM read, log2(e) multiply,
// table interpolation, rounding shift, write back) writes exp values to a
// second RAM and sums them, then a divide pass emits one probability per
// class on rsp_, each after a RAM read, a divider start, 34 divider
// steps and the divider's done pulse, held until the output handshake.
// An empty vector emits nothing.
module softmax_normalizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] logit
   input  logic        req_tlast,   // final_element
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] probability, [19:16] class_index, zero pad
   output logic        rsp_tlast,   // final_class
   output logic        rsp_tuser    // truncated
);
   import smx_pkg::*;

   typedef enum logic [9:0] {
      S_LOAD  = 10'b0000000001,
      S_ERD   = 10'b0000000010,
      S_EMUL  = 10'b0000000100,
      S_EINT  = 10'b0000001000,
      S_ESHF  = 10'b0000010000,
      S_EWR   = 10'b0000100000,
      S_DRD   = 10'b0001000000,
      S_DSTRT = 10'b0010000000,
      S_DWAIT = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type          state_ff, state_in;
   logic signed [15:0] max_ff, max_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [SumW-1:0]    sum_ff, sum_in;
   logic               ovf_ff, ovf_in;
   logic [IdxW-1:0]    idx_ff, idx_in;
   logic [33:0]        prod_ff, prod_in;
   logic [16:0]        mant_ff, mant_in;
   logic [ExpW-1:0]    exp_ff, exp_in;
   logic [15:0]        prob_ff, prob_in;

   logic               lg_we, ex_we, req_xfer;
   logic [IdxW-1:0]    lg_ra, ex_ra;
   logic [15:0]        lg_rd;
   logic [ExpW-1:0]    ex_rd;
   logic               div_start, div_done;
   logic [15:0]        div_q;

   logic [16:0]        mag;
   logic [17:0]        t_q;
   logic [9:0]         n_int;
   logic [7:0]         frac;
   logic [16:0]        ta, tb;
   logic [20:0]        dlt;
   logic [4:0]         sh;

   assign req_tready = (state_ff == S_LOAD);
   assign req_xfer   = req_tvalid && req_tready;

   smx_ram #(.Width(16), .Depth(MaxClasses)) u_logit_ram (
      .clock(clock), .wr_en(lg_we), .wr_addr(cnt_ff[IdxW-1:0]),
      .wr_data(req_tdata), .rd_addr(lg_ra), .rd_data(lg_rd));

   smx_ram #(.Width(ExpW), .Depth(MaxClasses)) u_exp_ram (
      .clock(clock), .wr_en(ex_we), .wr_addr(idx_ff),
      .wr_data(exp_ff), .rd_addr(ex_ra), .rd_data(ex_rd));

   smx_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(ex_rd), .den(sum_ff), .done(div_done), .quot(div_q));

   assign lg_ra = idx_ff;
   assign ex_ra = idx_ff;
   assign lg_we = req_xfer && (cnt_ff < CntW'(MaxClasses));
   assign ex_we = (state_ff == S_EWR);
   assign div_start = (state_ff == S_DSTRT);

   // exponential datapath pieces
   assign mag   = 17'({max_ff[15], max_ff} - {lg_rd[15], lg_rd});
   assign t_q   = 18'((prod_ff + 34'd32768) >> 16);
   assign n_int = t_q[17:8];
   assign frac  = t_q[7:0];
   assign ta    = pow2_tab({1'b0, frac[7:4]});
   assign tb    = pow2_tab(5'({1'b0, frac[7:4]} + 5'd1));
   assign dlt   = 21'((21'(ta - tb) * 21'(frac[3:0]) + 21'd8) >> 4);
   assign sh    = 5'(prod_ff[4:0]);

   always_comb begin
      state_in = state_ff;
      max_in   = max_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      prod_in  = prod_ff;
      mant_in  = mant_ff;
      exp_in   = exp_ff;
      prob_in  = prob_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_xfer) begin
               // store the logit, track max, or drop it when full
               if (cnt_ff < CntW'(MaxClasses)) begin
                  cnt_in = cnt_ff + 1'b1;
                  if ($signed(req_tdata) > max_ff) begin
                     max_in = $signed(req_tdata);
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  idx_in = '0;
                  sum_in = '0;
                  state_in = S_ERD;
               end
            end
         end
         S_ERD: begin
            if (cnt_ff == '0) begin
               state_in = S_LOAD;
               max_in = 16'sh8000;
               ovf_in = 1'b0;
            end else begin
               state_in = S_EMUL;
            end
         end
         S_EMUL: begin
            prod_in  = 34'(mag) * 34'(Log2eQ16);
            state_in = S_EINT;
         end
         S_EINT: begin
            // interpolate mantissa; keep shift count in prod low bits
            mant_in = 17'(21'(ta) - dlt);
            prod_in = (n_int > 10'd17) ? 34'd31 : 34'(n_int);
            state_in = S_ESHF;
         end
         S_ESHF: begin
            if (sh == 5'd31) begin
               exp_in = '0;
            end else if (sh == 5'd0) begin
               exp_in = mant_ff;
            end else begin
               exp_in = 17'((18'(mant_ff) + (18'd1 << (sh - 5'd1))) >> sh);
            end
            state_in = S_EWR;
         end
         S_EWR: begin
            sum_in = sum_ff + SumW'(exp_ff);
            if (CntW'(idx_ff) + 1'b1 == cnt_ff) begin
               idx_in = '0;
               state_in = S_DRD;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_ERD;
            end
         end
         S_DRD: begin
            state_in = S_DSTRT;
         end
         S_DSTRT: begin
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               prob_in = div_q;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (CntW'(idx_ff) + 1'b1 == cnt_ff) begin
                  // close the run
                  state_in = S_LOAD;
                  max_in = 16'sh8000;
                  cnt_in = '0;
                  sum_in = '0;
                  ovf_in = 1'b0;
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = S_DRD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         max_ff   <= 16'sh8000;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         max_ff   <= max_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
         idx_ff   <= idx_in;
      end
      prod_ff <= prod_in;
      mant_ff <= mant_in;
      exp_ff  <= exp_in;
      prob_ff <= prob_in;
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {4'd0, 4'(idx_ff), prob_ff};
   assign rsp_tlast  = (CntW'(idx_ff) + 1'b1 == cnt_ff);
   assign rsp_tuser  = ovf_ff;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   import smx_pkg::*;

   typedef struct packed {
      logic [15:0] prob;
      logic [3:0]  idx;
      logic        last;
      logic        trunc;
   } prob_type;

   typedef struct {
      logic [15:0] logit;
      logic        fin;
      logic        has_prob;
      logic [15:0] prob;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   softmax_normalizer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   // predictor state
   logic signed [15:0] held_logit[MaxClasses];
   logic signed [15:0] peak_logit;
   int                 held_count;
   logic               dropped;

   prob_type    prob_queue[$];
   logic        fixed_valid[$];
   logic [15:0] fixed_prob[$];

   int error_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_off = 1'b0;
   int quiet_cycles = 0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int pow2_entry(input int k);
      int t[17] = '{65536, 62757, 60096, 57549, 55109, 52773, 50535, 48393,
                    46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
      return t[k];
   endfunction

   // exp of a non-positive difference given by its magnitude, Q1.16
   function automatic longint exp_of_gap(input longint mag);
      longint tq, n, f, a, b, m;
      tq = (mag * Log2eQ16 + 32768) >>> 16;
      n  = tq >>> 8;
      f  = tq & 255;
      a  = pow2_entry(int'(f >>> 4));
      b  = pow2_entry(int'(f >>> 4) + 1);
      m  = a - (((a - b) * (f & 15) + 8) >>> 4);
      if (n == 0) return m;
      if (n > 17) return 0;
      return (m + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic void clear_vector();
      peak_logit = -16'sd32768;
      held_count = 0;
      dropped = 1'b0;
   endfunction

   // absorb one logit; on the closing one queue the probabilities
   function automatic void absorb_logit(input logic [15:0] lg, input logic fin,
                                        input logic has_fixed, input logic [15:0] fp);
      longint ex[MaxClasses];
      longint total;
      longint p;
      prob_type r;
      if (held_count < MaxClasses) begin
         held_logit[held_count] = lg;
         held_count++;
         if ($signed(lg) > peak_logit) peak_logit = lg;
      end else begin
         dropped = 1'b1;
      end
      if (!fin) return;
      total = 0;
      for (int i = 0; i < held_count; i++) begin
         ex[i] = exp_of_gap(longint'(peak_logit) - longint'(held_logit[i]));
         total += ex[i];
      end
      if (total != 0) begin
         for (int i = 0; i < held_count; i++) begin
            p = ((ex[i] << 16) + (total >>> 1)) / total;
            if (p > 65535) p = 65535;
            r.prob  = p[15:0];
            r.idx   = i[3:0];
            r.last  = (i + 1 == held_count);
            r.trunc = dropped;
            prob_queue.push_back(r);
            fixed_valid.push_back(has_fixed && i == 0);
            fixed_prob.push_back(fp);
         end
      end
      clear_vector();
   endfunction

   // stall randomly; long hold-off blocks the receiver
   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else          rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // check each result transfer and count cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (prob_queue.size() == 0) begin
            report("unexpected result, probability", rsp_tdata[15:0], -1);
         end else begin
            prob_type w;
            logic fv;
            logic [15:0] fpv;
            w = prob_queue.pop_front();
            fv = fixed_valid.pop_front();
            fpv = fixed_prob.pop_front();
            if (rsp_tdata[15:0] !== w.prob) report("probability", rsp_tdata[15:0], w.prob);
            if (fv && rsp_tdata[15:0] !== fpv) report("table probability", rsp_tdata[15:0], fpv);
            if (rsp_tdata[19:16] !== w.idx) report("class_index", rsp_tdata[19:16], w.idx);
            if (rsp_tdata[23:20] !== 4'd0) report("padding", rsp_tdata[23:20], 0);
            if (rsp_tlast !== w.last) report("final_class", rsp_tlast, w.last);
            if (rsp_tuser !== w.trunc) report("truncated", rsp_tuser, w.trunc);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (quiet_cycles > 20000) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic send_logit(input logic [15:0] lg, input logic fin,
                             input logic has_fixed, input logic [15:0] fp);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= lg;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_logit(lg, fin, has_fixed, fp);
   endtask

   task automatic send_vector(input int len, input int mode);
      logic [15:0] lg;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: lg = 16'($urandom);
            1: lg = 16'($urandom_range(0, 2047) - 1024);
            default: lg = 16'($urandom_range(0, 4095)) - 16'd2048 + 16'($urandom_range(0, 1) * 16'h4000);
         endcase
         send_logit(lg, i == len - 1, 1'b0, 16'd0);
      end
   endtask

   // the expected value, where given, is that of the first class of the vector
   stim_row_type directed[] = '{
      // single class: probability saturates
      '{16'h0000, 1'b1, 1'b1, 16'd65535},
      '{16'h7FFF, 1'b1, 1'b1, 16'd65535},
      '{16'h8000, 1'b1, 1'b1, 16'd65535},
      // two equal logits: one half each
      '{16'h0100, 1'b0, 1'b0, 16'd0},
      '{16'h0100, 1'b1, 1'b1, 16'd32768},
      // extremes apart: tiny class rounds to zero
      '{16'h8000, 1'b0, 1'b0, 16'd0},
      '{16'h7FFF, 1'b1, 1'b1, 16'd0},
      '{16'h0080, 1'b0, 1'b0, 16'd0},
      '{16'hFF00, 1'b0, 1'b0, 16'd0},
      '{16'h0010, 1'b1, 1'b0, 16'd0}
   };

   int phase_idle[4]  = '{0, 49, 0, 13};
   int phase_stall[4] = '{0, 0, 49, 13};

   initial begin
      clear_vector();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed[i])
         send_logit(directed[i].logit, directed[i].fin,
                    directed[i].has_prob, directed[i].prob);
      // overflow: 18 logits, the last two dropped, one closing the vector
      for (int i = 0; i < 18; i++)
         send_logit(16'(i * 64), i == 17, 1'b0, 16'd0);

      // long receiver hold-off while a vector and more load in
      hold_off = 1'b1;
      fork
         begin
            send_vector(5, 1);
            send_vector(4, 2);
         end
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
      join

      // random phases of pacing
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = phase_idle[ph];
         stall_pct = phase_stall[ph];
         for (int n = 0; n < 105; ) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
            send_vector(len, $urandom_range(0, 2));
            n += len;
         end
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      stall_pct = 0;

      while (prob_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
